[rtl/core/imurf_pkg.sv]
// ----------------------------------------------------------------------------
// IMU register file package
// Shared types, register addresses and scaling tables for the register file.
// ----------------------------------------------------------------------------
package imurf_pkg;

   localparam int REG_COUNT          = 128;
   localparam int REG_ADDR_WIDTH     = $clog2(REG_COUNT);
   localparam int UPLOAD_COUNT_WIDTH = 16;
   localparam int QUEUE_DEPTH        = 2;
   localparam int DIVISOR_WIDTH      = 33;
   localparam int DIVIDEND_WIDTH     = 64;

   localparam logic [7:0] A_ACC_DATA   = 8'h0C;
   localparam logic [7:0] A_GYR_DATA   = 8'h12;
   localparam logic [7:0] A_STATUS     = 8'h21;
   localparam logic [7:0] A_ACC_RANGE  = 8'h41;
   localparam logic [7:0] A_GYR_RANGE  = 8'h43;
   localparam logic [7:0] A_INIT_CTRL  = 8'h59;
   localparam logic [6:0] A_INIT_DATA  = 7'h5E;
   localparam logic [7:0] A_PWR_CONF   = 8'h7C;
   localparam logic [7:0] A_CMD        = 8'h7E;
   localparam logic [7:0] A_ID         = 8'h00;
   localparam logic [7:0] V_ID         = 8'h24;
   localparam logic [7:0] V_SOFT_RESET = 8'hB6;
   localparam logic [7:0] V_PWR_DEF    = 8'h03;
   localparam logic [7:0] V_ACC_DEF    = 8'h02;
   localparam logic [7:0] V_INIT_OK    = 8'h01;

   localparam logic [1:0] FUNC_READ   = 2'd0;
   localparam logic [1:0] FUNC_WRITE  = 2'd1;
   localparam logic [1:0] FUNC_INJECT = 2'd2;

   typedef enum logic [2:0] {
      CLS_NOP,
      CLS_READ,
      CLS_WRITE,
      CLS_UPLOAD,
      CLS_SRESET,
      CLS_INJECT
   } cls_type;

   typedef struct packed {
      cls_type            cls;
      logic [7:0]         addr;
      logic [7:0]         wdata;
      logic [2:0]         channel;
      logic signed [31:0] value;
      logic [3:0]         shift;
   } entry_type;

   typedef struct packed {
      logic [$clog2(QUEUE_DEPTH+1)-1:0] count;
   } front_status_type;

   function automatic logic [7:0] reset_value(input logic [REG_ADDR_WIDTH-1:0] a);
      logic [7:0] v;
      v = 8'h00;
      if ({1'b0, a} == A_ID)           v = V_ID;
      else if ({1'b0, a} == A_PWR_CONF) v = V_PWR_DEF;
      else if ({1'b0, a} == A_ACC_RANGE) v = V_ACC_DEF;
      return v;
   endfunction

   function automatic logic [DIVISOR_WIDTH-1:0] accel_scale(input logic [1:0] k);
      logic [DIVISOR_WIDTH-1:0] v;
      unique case (k)
         2'd0: v = 33'd19613300;
         2'd1: v = 33'd39226600;
         2'd2: v = 33'd78453200;
         default: v = 33'd156906400;
      endcase
      return v;
   endfunction

   // Degrees-per-second range times pi in micro units.
   function automatic logic [DIVISOR_WIDTH-1:0] gyro_scale(input logic [2:0] k);
      logic [DIVISOR_WIDTH-1:0] v;
      unique case (k)
         3'd0: v = 33'd6283184000;
         3'd1: v = 33'd3141592000;
         3'd2: v = 33'd1570796000;
         3'd3: v = 33'd785398000;
         3'd4: v = 33'd392699000;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[rtl/core/imurf_front.sv]
// ----------------------------------------------------------------------------
// IMU register file front end
// Accepts requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module imurf_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_func,
   input  logic [6:0]                req_burst_start,
   input  logic [7:0]                req_burst_offset,
   input  logic [7:0]                req_write_data,
   input  logic [2:0]                req_channel,
   input  logic signed [31:0]        req_sample_value,
   input  logic [3:0]                req_sample_shift,
   output logic                      head_valid,
   output imurf_pkg::entry_type      head,
   input  logic                      pop,
   output imurf_pkg::front_status_type status
);
   import imurf_pkg::*;

   entry_type queue_ff [QUEUE_DEPTH];
   logic [$clog2(QUEUE_DEPTH)-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [$clog2(QUEUE_DEPTH+1)-1:0] count_ff, count_in;
   entry_type entry;
   logic [7:0] eff;
   logic push, do_pop;

   always_comb begin
      eff = 8'({1'b0, req_burst_start} + req_burst_offset);
      entry.addr    = eff;
      entry.wdata   = req_write_data;
      entry.channel = req_channel;
      entry.value   = req_sample_value;
      entry.shift   = req_sample_shift;
      entry.cls     = CLS_NOP;
      priority if (req_func == FUNC_READ) begin
         entry.cls = (eff[7] == 1'b0) ? CLS_READ : CLS_NOP;
      end else if (req_func == FUNC_WRITE) begin
         if (req_burst_start == A_INIT_DATA) entry.cls = CLS_UPLOAD;
         else if (eff[7]) entry.cls = CLS_NOP;
         else if (eff == A_CMD)
            entry.cls = (req_write_data == V_SOFT_RESET) ? CLS_SRESET : CLS_NOP;
         else entry.cls = CLS_WRITE;
      end else if (req_func == FUNC_INJECT) begin
         entry.cls = (req_channel <= 3'd5) ? CLS_INJECT : CLS_NOP;
      end else begin
         entry.cls = CLS_NOP;
      end
   end

   assign req_stall  = (count_ff == ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH));
   assign push       = req_valid && !req_stall;
   assign head_valid = (count_ff != '0);
   assign do_pop     = pop && head_valid;
   assign head       = queue_ff[rptr_ff];
   assign status.count = count_ff;

   always_comb begin
      wptr_in  = push   ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + (($clog2(QUEUE_DEPTH+1))'(push))
                 - (($clog2(QUEUE_DEPTH+1))'(do_pop));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) queue_ff[wptr_ff] <= entry;
   end

endmodule

[rtl/core/imurf_div.sv]
// ----------------------------------------------------------------------------
// IMU register file divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module imurf_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [imurf_pkg::DIVIDEND_WIDTH-1:0]  dividend,
   input  logic [imurf_pkg::DIVISOR_WIDTH-1:0]   divisor,
   output logic                                  done,
   output logic [imurf_pkg::DIVIDEND_WIDTH-1:0]  quotient
);
   import imurf_pkg::*;

   logic [DIVIDEND_WIDTH-1:0] dvd_ff, dvd_in;
   logic [DIVISOR_WIDTH-1:0]  rem_ff, rem_in, dsr_ff;
   logic [DIVISOR_WIDTH:0]    rem_sh;
   logic [$clog2(DIVIDEND_WIDTH)-1:0] cnt_ff;
   logic busy_ff, done_ff, ge;

   always_comb begin
      rem_sh = {rem_ff, dvd_ff[DIVIDEND_WIDTH-1]};
      ge     = rem_sh >= {1'b0, dsr_ff};
      rem_in = ge ? DIVISOR_WIDTH'(rem_sh - {1'b0, dsr_ff}) : rem_sh[DIVISOR_WIDTH-1:0];
      dvd_in = {dvd_ff[DIVIDEND_WIDTH-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == '1) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
      end else if (busy_ff) begin
         dvd_ff <= dvd_in;
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

[rtl/core/imurf_back.sv]
// ----------------------------------------------------------------------------
// IMU register file back end
// Holds the register memory and carries out reads, writes and injections.
// ----------------------------------------------------------------------------
module imurf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  imurf_pkg::entry_type   head,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_read_data,
   output logic                   rsp_error_flag,
   output logic [15:0]            rsp_upload_count
);
   import imurf_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_STAT, S_MUL1, S_SHIFT, S_MUL2, S_MUL3,
      S_DIVGO, S_DIVW, S_WLO, S_WHI, S_RESP
   } state_type;

   state_type state_ff;
   logic [7:0] mem [REG_COUNT];
   logic [REG_COUNT-1:0] valid_ff;
   logic [7:0] mem_q_ff;
   logic [REG_ADDR_WIDTH-1:0] raddr_ff;
   logic [UPLOAD_COUNT_WIDTH-1:0] cnt_ff;
   logic [1:0] acc_rng_ff;
   logic [2:0] gyr_rng_ff;
   logic [7:0] rd_ff, base_ff;
   logic err_ff, gyro_ff, neg_ff;
   logic signed [31:0] value_ff;
   logic [3:0] shift_ff;
   logic [DIVISOR_WIDTH-1:0] dsr_ff;
   logic signed [52:0] p1_ff;
   logic signed [35:0] si_ff;
   logic signed [51:0] p2_ff;
   logic signed [60:0] p3_ff;
   logic [15:0] raw_ff, raw_in;
   logic rsp_valid_ff, rsp_err_ff;
   logic [7:0] rsp_rd_ff;
   logic [15:0] rsp_cnt_ff;
   logic out_free;
   logic mem_we;
   logic [REG_ADDR_WIDTH-1:0] mem_wa;
   logic [7:0] mem_wd;
   logic div_start, div_done;
   logic [DIVIDEND_WIDTH-1:0] div_q, dividend;
   logic [59:0] mag;

   imurf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (dsr_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign pop       = (state_ff == S_IDLE) && head_valid;
   assign div_start = (state_ff == S_DIVGO);
   assign mag       = p3_ff[60] ? 60'(-p3_ff) : 60'(p3_ff);
   assign dividend  = DIVIDEND_WIDTH'(mag);

   always_comb begin
      mem_we = 1'b0;
      mem_wa = head.addr[REG_ADDR_WIDTH-1:0];
      mem_wd = head.wdata;
      unique case (state_ff)
         S_IDLE: mem_we = pop && (head.cls == CLS_WRITE);
         S_STAT: begin
            mem_we = 1'b1;
            mem_wa = A_STATUS[REG_ADDR_WIDTH-1:0];
            mem_wd = V_INIT_OK;
         end
         S_WLO: begin
            mem_we = 1'b1;
            mem_wa = base_ff[REG_ADDR_WIDTH-1:0];
            mem_wd = raw_ff[7:0];
         end
         S_WHI: begin
            mem_we = 1'b1;
            mem_wa = REG_ADDR_WIDTH'(base_ff + 8'd1);
            mem_wd = raw_ff[15:8];
         end
         default: mem_we = 1'b0;
      endcase
   end

   // Truncating quotient magnitude, sign restored, then clamped to int16.
   always_comb begin
      if (neg_ff) raw_in = (div_q > 64'd32768) ? 16'h8000 : 16'(-div_q[15:0]);
      else        raw_in = (div_q > 64'd32767) ? 16'h7FFF : div_q[15:0];
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_q_ff <= mem[head.addr[REG_ADDR_WIDTH-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         cnt_ff       <= '0;
         acc_rng_ff   <= V_ACC_DEF[1:0];
         gyr_rng_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // A response stays valid until its transfer completes.
         rsp_valid_ff <= (state_ff == S_RESP) || (rsp_valid_ff && rsp_stall);
         if (mem_we) valid_ff[mem_wa] <= 1'b1;
         unique case (state_ff)
            S_IDLE: begin
               if (pop) begin
                  rd_ff    <= '0;
                  err_ff   <= (head.cls == CLS_INJECT) && (head.channel >= 3'd3)
                              && (gyr_rng_ff > 3'd4);
                  raddr_ff <= head.addr[REG_ADDR_WIDTH-1:0];
                  value_ff <= head.value;
                  shift_ff <= head.shift;
                  gyro_ff  <= (head.channel >= 3'd3);
                  unique case (head.cls)
                     CLS_READ: state_ff <= S_READ;
                     CLS_UPLOAD: begin
                        if (cnt_ff != '1) cnt_ff <= cnt_ff + 1'b1;
                        state_ff <= S_RESP;
                     end
                     CLS_SRESET: begin
                        valid_ff   <= '0;
                        cnt_ff     <= '0;
                        acc_rng_ff <= V_ACC_DEF[1:0];
                        gyr_rng_ff <= '0;
                        state_ff   <= S_RESP;
                     end
                     CLS_WRITE: begin
                        if (head.addr == A_ACC_RANGE) acc_rng_ff <= head.wdata[1:0];
                        if (head.addr == A_GYR_RANGE) gyr_rng_ff <= head.wdata[2:0];
                        if (head.addr == A_INIT_CTRL && head.wdata == 8'h01 && cnt_ff != '0)
                           state_ff <= S_STAT;
                        else
                           state_ff <= S_RESP;
                     end
                     CLS_INJECT: begin
                        if (head.channel >= 3'd3) begin
                           base_ff <= 8'(A_GYR_DATA + {4'd0, head.channel - 3'd3, 1'b0});
                           dsr_ff  <= gyro_scale(gyr_rng_ff);
                           if (gyr_rng_ff > 3'd4) state_ff <= S_RESP;
                           else state_ff <= S_MUL1;
                        end else begin
                           base_ff  <= 8'(A_ACC_DATA + {4'd0, head.channel, 1'b0});
                           dsr_ff   <= accel_scale(acc_rng_ff);
                           state_ff <= S_MUL1;
                        end
                     end
                     default: state_ff <= S_RESP;
                  endcase
               end
            end
            S_READ: begin
               rd_ff    <= valid_ff[raddr_ff] ? mem_q_ff : reset_value(raddr_ff);
               state_ff <= S_RESP;
            end
            S_STAT:  state_ff <= S_RESP;
            S_MUL1: begin
               p1_ff    <= 53'(value_ff) * 53'sd1000000;
               state_ff <= S_SHIFT;
            end
            S_SHIFT: begin
               // Arithmetic shift floors toward minus infinity.
               si_ff    <= 36'(p1_ff >>> (5'd31 - {1'b0, shift_ff}));
               state_ff <= S_MUL2;
            end
            S_MUL2: begin
               p2_ff    <= 52'(si_ff) * 52'sd32767;
               state_ff <= S_MUL3;
            end
            S_MUL3: begin
               p3_ff    <= gyro_ff ? 61'(p2_ff) * 61'sd180 : 61'(p2_ff);
               state_ff <= S_DIVGO;
            end
            S_DIVGO: begin
               neg_ff   <= p3_ff[60];
               state_ff <= S_DIVW;
            end
            S_DIVW: begin
               if (div_done) begin
                  raw_ff   <= raw_in;
                  state_ff <= S_WLO;
               end
            end
            S_WLO: state_ff <= S_WHI;
            S_WHI: state_ff <= S_RESP;
            S_RESP: begin
               if (out_free) begin
                  rsp_rd_ff    <= rd_ff;
                  rsp_err_ff   <= err_ff;
                  rsp_cnt_ff   <= 16'(cnt_ff);
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_rd_ff;
   assign rsp_error_flag   = rsp_err_ff;
   assign rsp_upload_count = rsp_cnt_ff;

endmodule

[rtl/core/imu_register_file_model.sv]
// ----------------------------------------------------------------------------
// IMU register file model
// Byte-access register file of an inertial sensor with sample injection.
// ----------------------------------------------------------------------------
//   channel   direction   handshake
//   req_      in          req_valid / req_stall
//   rsp_      out         rsp_valid / rsp_stall
//
// A read passes the back-end states S_READ and S_RESP, a write S_RESP (S_STAT
// first when it raises the init status) and a valid injection S_MUL1 through
// S_WHI to S_RESP, waiting in S_DIVW on the one-bit-per-cycle 64-bit divider.
// Items run one at a time in the back end while a two-entry queue takes requests until it is full.
// Synchronous reset restores the register defaults at once through per-entry
// valid bits; no clearing pass is needed. A stalled response holds its data.
module imu_register_file_model (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  logic [6:0]         req_burst_start,
   input  logic [7:0]         req_burst_offset,
   input  logic [7:0]         req_write_data,
   input  logic [2:0]         req_channel,
   input  logic signed [31:0] req_sample_value,
   input  logic [3:0]         req_sample_shift,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_read_data,
   output logic               rsp_error_flag,
   output logic [15:0]        rsp_upload_count
);
   import imurf_pkg::*;

   entry_type        head;
   logic             head_valid, pop;
   front_status_type fstat;

   imurf_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_func         (req_func),
      .req_burst_start  (req_burst_start),
      .req_burst_offset (req_burst_offset),
      .req_write_data   (req_write_data),
      .req_channel      (req_channel),
      .req_sample_value (req_sample_value),
      .req_sample_shift (req_sample_shift),
      .head_valid       (head_valid),
      .head             (head),
      .pop              (pop),
      .status           (fstat)
   );

   imurf_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_valid       (head_valid),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_read_data    (rsp_read_data),
      .rsp_error_flag   (rsp_error_flag),
      .rsp_upload_count (rsp_upload_count)
   );

`ifndef NO_ASSERTIONS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      fstat.count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
      else $error("queue count exceeds depth");

   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_flag) |-> (rsp_read_data == 8'h00))
      else $error("error response carries read data");

   a_pop_has_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("back end popped an empty queue");
`endif

endmodule

[bench/imu_register_file_model_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IMU register file model testbench
// Drives byte reads, writes, upload bursts and sample injections through the
// request channel, predicts every response from a local register file image,
// and compares each response transfer field by field in arrival order.
// ----------------------------------------------------------------------------
module imu_register_file_model_tb;
   import imurf_pkg::*;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [7:0]  read_data;
      logic        error_flag;
      logic [15:0] upload_count;
   } rsp_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [1:0]         req_func;
   logic [6:0]         req_burst_start;
   logic [7:0]         req_burst_offset;
   logic [7:0]         req_write_data;
   logic [2:0]         req_channel;
   logic signed [31:0] req_sample_value;
   logic [3:0]         req_sample_shift;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [7:0]         rsp_read_data;
   logic               rsp_error_flag;
   logic [15:0]        rsp_upload_count;

   logic [7:0]  regs_image [REG_COUNT];
   logic [15:0] upload_image;
   rsp_type     expected_rsps [$];
   int          error_count;
   int          rsp_total;
   bit          stall_idle;

   imu_register_file_model i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("imu_register_file_model test failed");
      $finish;
   end

   function automatic int rand_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
      return $urandom_range(0, 4);
   endfunction

   task automatic image_soft_reset();
      for (int i = 0; i < REG_COUNT; i++) regs_image[i] = 8'h00;
      regs_image[A_ID]        = V_ID;
      regs_image[A_PWR_CONF]  = V_PWR_DEF;
      regs_image[A_ACC_RANGE] = V_ACC_DEF;
      regs_image[A_GYR_RANGE] = 8'h00;
      upload_image = '0;
   endtask

   // Q31 to raw counts; returns 1 on an unsupported gyro range.
   function automatic bit image_inject(logic [2:0] ch, logic signed [31:0] val,
                                       logic [3:0] sh);
      longint prod, si, raw, dps;
      longint unsigned mag;
      int s;
      int base;
      s = 31 - sh;
      prod = longint'(val) * 64'sd1000000;
      if (prod >= 0) si = prod >>> s;
      else begin
         mag = -prod;
         mag = (mag + ((64'd1 << s) - 1)) >> s;
         si = -longint'(mag);
      end
      if (ch <= 2) begin
         raw = si * 32767 / (longint'(2 << regs_image[A_ACC_RANGE][1:0]) * 9806650);
         base = A_ACC_DATA + 2 * ch;
      end else if (ch <= 5) begin
         case (regs_image[A_GYR_RANGE][2:0])
            3'd0: dps = 2000;
            3'd1: dps = 1000;
            3'd2: dps = 500;
            3'd3: dps = 250;
            3'd4: dps = 125;
            default: return 1'b1;
         endcase
         raw = si * 32767 * 180 / (dps * 3141592);
         base = A_GYR_DATA + 2 * (ch - 3);
      end else begin
         return 1'b0;
      end
      if (raw > 32767) raw = 32767;
      if (raw < -32768) raw = -32768;
      regs_image[base]     = raw[7:0];
      regs_image[base + 1] = raw[15:8];
      return 1'b0;
   endfunction

   task automatic predict_access(logic [1:0] func, logic [6:0] start, logic [7:0] off,
                                 logic [7:0] wd, logic [2:0] ch,
                                 logic signed [31:0] val, logic [3:0] sh);
      rsp_type r;
      logic [7:0] a;
      a = {1'b0, start} + off;
      r.read_data = 8'h00;
      r.error_flag = 1'b0;
      if (func == FUNC_READ) begin
         if (a < REG_COUNT) r.read_data = regs_image[a[6:0]];
      end else if (func == FUNC_WRITE) begin
         if (start == A_INIT_DATA) begin
            if (upload_image != 16'hFFFF) upload_image++;
         end else if (a < REG_COUNT) begin
            if (a == A_CMD) begin
               if (wd == V_SOFT_RESET) image_soft_reset();
            end else begin
               regs_image[a[6:0]] = wd;
               if (a == A_INIT_CTRL && wd == 8'h01 && upload_image != 0)
                  regs_image[A_STATUS] = V_INIT_OK;
            end
         end
      end else if (func == FUNC_INJECT) begin
         r.error_flag = image_inject(ch, val, sh);
      end
      r.upload_count = upload_image;
      expected_rsps.push_back(r);
   endtask

   // The request stays valid after its transfer until the next gap or item.
   task automatic send_access(logic [1:0] func, logic [6:0] start, logic [7:0] off,
                              logic [7:0] wd = 8'h00, logic [2:0] ch = 3'd0,
                              logic signed [31:0] val = 32'sd0,
                              logic [3:0] sh = 4'd0);
      int gap;
      gap = rand_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_burst_start  <= start;
      req_burst_offset <= off;
      req_write_data   <= wd;
      req_channel      <= ch;
      req_sample_value <= val;
      req_sample_shift <= sh;
      do @(posedge clock); while (req_stall);
      predict_access(func, start, off, wd, ch, val, sh);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch on response %0d: %s got %0h expected %0h",
               rsp_total, what, got, want);
      error_count++;
   endtask

   // Response checker.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected transfer", 1, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_read_data !== want.read_data)
               report_mismatch("read_data", rsp_read_data, want.read_data);
            if (rsp_error_flag !== want.error_flag)
               report_mismatch("error_flag", rsp_error_flag, want.error_flag);
            if (rsp_upload_count !== want.upload_count)
               report_mismatch("upload_count", rsp_upload_count, want.upload_count);
         end
         rsp_total++;
      end
   end

   // Receiver stall: random stretches, with some quiet periods.
   initial begin
      int n;
      rsp_stall = 1'b0;
      forever begin
         n = rand_gap();
         @(negedge clock);
         rsp_stall <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
         if (!stall_idle && n != 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(negedge clock);
         end
      end
   end

   task automatic test_reset_values();
      for (int a = 0; a < 256; a += 17) send_access(FUNC_READ, 7'd0, a[7:0]);
      send_access(FUNC_READ, 7'h7F, 8'hFF);
      send_access(FUNC_READ, A_ACC_RANGE[6:0], 8'd0);
      send_access(FUNC_READ, A_PWR_CONF[6:0], 8'd0);
   endtask

   task automatic test_special_registers();
      send_access(FUNC_WRITE, 7'h10, 8'h80, 8'hFF);           // dropped above 127
      send_access(FUNC_WRITE, A_INIT_CTRL[6:0], 8'd0, 8'h01); // no upload yet
      send_access(FUNC_READ, A_STATUS[6:0], 8'd0);
      send_access(FUNC_WRITE, A_INIT_DATA, 8'hFF, 8'h55);
      send_access(FUNC_WRITE, A_INIT_DATA, 8'h00, 8'hAA);
      send_access(FUNC_WRITE, A_INIT_CTRL[6:0], 8'd0, 8'h01);
      send_access(FUNC_READ, A_STATUS[6:0], 8'd0);
      send_access(FUNC_WRITE, A_CMD[6:0], 8'd0, 8'h11);       // ignored command
      send_access(FUNC_READ, A_CMD[6:0], 8'd0);
      send_access(FUNC_UNUSED, 7'h7F, 8'hFF, 8'hFF);
      send_access(FUNC_INJECT, 7'd0, 8'd0, 8'd0, 3'd7, 32'sh7FFFFFFF, 4'd15);
      send_access(FUNC_WRITE, A_GYR_RANGE[6:0], 8'd0, 8'h05);
      send_access(FUNC_INJECT, 7'd0, 8'd0, 8'd0, 3'd4, 32'sd1000, 4'd3);
      send_access(FUNC_WRITE, A_CMD[6:0], 8'd0, V_SOFT_RESET);
      send_access(FUNC_READ, A_GYR_RANGE[6:0], 8'd0);
      // Idle pause: let everything drain before going on.
      wait_drained();
      send_access(FUNC_READ, A_ID[6:0], 8'd0);
   endtask

   task automatic test_injection_extremes();
      for (int k = 0; k < 4; k++) begin
         send_access(FUNC_WRITE, A_ACC_RANGE[6:0], 8'd0, k[7:0]);
         send_access(FUNC_INJECT, 7'd0, 8'd0, 8'd0, 3'd0, 32'sh7FFFFFFF, 4'd15);
         send_access(FUNC_INJECT, 7'd0, 8'd0, 8'd0, 3'd2, 32'sh80000000, 4'd4);
      end
      for (int k = 0; k < 8; k++) begin
         send_access(FUNC_WRITE, A_GYR_RANGE[6:0], 8'd0, k[7:0]);
         send_access(FUNC_INJECT, 7'd0, 8'd0, 8'd0, 3'd5, -32'sd123456789, 4'd0);
      end
      send_access(FUNC_INJECT, 7'd0, 8'd0, 8'd0, 3'd1, -32'sd1, 4'd0);
      for (int a = A_ACC_DATA; a < A_GYR_DATA + 6; a++)
         send_access(FUNC_READ, 7'd0, a[7:0]);
   endtask

   task automatic test_random_traffic(int count);
      logic [1:0] func;
      logic [6:0] start;
      logic [7:0] off, wd;
      int sel;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         start = 7'($urandom);
         off = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
         wd = 8'($urandom);
         if (sel < 35) func = FUNC_READ;
         else if (sel < 70) func = FUNC_WRITE;
         else if (sel < 97) func = FUNC_INJECT;
         else func = FUNC_UNUSED;
         if (func == FUNC_WRITE) begin
            case ($urandom_range(0, 9))
               0, 1: start = A_INIT_DATA;
               2: begin
                  start = A_INIT_CTRL[6:0]; off = 8'd0;
                  wd = 8'($urandom_range(0, 1));
               end
               3: begin start = A_ACC_RANGE[6:0]; off = 8'd0; end
               4: begin
                  start = A_GYR_RANGE[6:0]; off = 8'd0;
                  wd = 8'($urandom_range(0, 7));
               end
               5: begin
                  start = A_CMD[6:0]; off = 8'd0;
                  if ($urandom_range(0, 3) == 0) wd = V_SOFT_RESET;
               end
               default: ;
            endcase
         end
         if (i == count / 2) wait_drained();
         stall_idle = (i / 100) % 3 == 1;
         send_access(func, start, off, wd, 3'($urandom_range(0, 7)), 32'($urandom),
                     4'($urandom));
      end
      stall_idle = 1'b0;
   endtask

   initial begin
      error_count = 0;
      rsp_total = 0;
      stall_idle = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_READ;
      req_burst_start = '0;
      req_burst_offset = '0;
      req_write_data = '0;
      req_channel = '0;
      req_sample_value = '0;
      req_sample_shift = '0;
      image_soft_reset();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_values();
      test_special_registers();
      test_injection_extremes();
      test_random_traffic(700);
      wait_drained();
      repeat (200) @(negedge clock);
      $display("Covered reads, writes, upload bursts, soft resets and injections;");
      $display("%0d responses checked, %0d mismatches.", rsp_total, error_count);
      if (error_count == 0 && expected_rsps.size() == 0)
         $display("imu_register_file_model test passed");
      else
         $display("imu_register_file_model test failed");
      $finish;
   end

endmodule
